>>> hw/rtl/tzs_pkg.sv
// ----------------------------------------------------------------------------
// tzs_pkg: shared types and constants for the triangle z-slice block
// Coordinate and difference types, pipeline depth constants, edge codes.
// ----------------------------------------------------------------------------
package tzs_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int DIV_STEPS = COORD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic [COORD_W-1:0]        mag_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vert_t;

    typedef struct packed {
        vert_t p;
        vert_t q;
    } edge_t;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

endpackage

>>> hw/rtl/tzs_if.sv
// ----------------------------------------------------------------------------
// tzs_if: request channels of the triangle z-slice block
// Triangle input, segment output and slice height write channel.
// ----------------------------------------------------------------------------
interface tzs_tri_if import tzs_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    output ready);
endinterface

interface tzs_seg_if import tzs_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, hit, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, hit, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tzs_cfg_if import tzs_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/triangle_z_slice.sv
// ----------------------------------------------------------------------------
// triangle_z_slice: slice a triangle with a horizontal plane
// Crossing-edge interpolation through a pipelined divider, then orientation
// of the segment from the sign of the unnormalized normal.
// ----------------------------------------------------------------------------
// Most of the pipeline depth lies in the 32-stage restoring divider
// (one quotient bit per stage, four lanes).
// Throughput: one triangle per cycle while the output is not stalled; every
// stage is a register stage. A stalled output freezes the whole pipeline in place.
// Reset: rst_n clears all valid bits and sets slice_z to 0.
module triangle_z_slice import tzs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tzs_cfg_if.sink  cfg,
    tzs_tri_if.sink  tri_in,
    tzs_seg_if.source seg_out
);

    localparam int NL = 4;   // lanes: pt0.x, pt0.y, pt1.x, pt1.y

    function automatic edge_t pick_edge(input logic [1:0] k, input vert_t a,
                                        input vert_t b, input vert_t c);
        edge_t e;
        case (k)
            EDGE_AB: begin e.p = a; e.q = b; end
            EDGE_BC: begin e.p = b; e.q = c; end
            EDGE_CA: begin e.p = c; e.q = a; end
            default: begin e.p = a; e.q = b; end
        endcase
        return e;
    endfunction

    function automatic diff_t sub33(input coord_t u, input coord_t v);
        return $signed({u[COORD_W-1], u}) - $signed({v[COORD_W-1], v});
    endfunction

    function automatic mag_t abs33(input diff_t v);
        diff_t t;
        t = v[DIFF_W-1] ? -v : v;
        return t[COORD_W-1:0];
    endfunction

    logic en;
    assign en = !seg_out.valid || seg_out.ready;
    assign tri_in.ready = en;
    assign cfg.ready = 1'b1;

    coord_t slice_z_reg;

    // ---------------- stage A: captured triangle
    logic   va_reg;
    vert_t  a_reg, b_reg, c_reg;
    coord_t z_reg;

    // stage A comb
    logic le_a, le_b, le_c, ge_a, ge_b, ge_c;
    logic cr0, cr1, cr2, hit_a;
    logic [1:0] sel0, sel1;
    edge_t e0, e1;
    coord_t p0_a [NL];
    diff_t  d_a [NL], n_a [NL], m_a [NL];

    always_comb
    begin
        le_a = a_reg.z <= z_reg;
        le_b = b_reg.z <= z_reg;
        le_c = c_reg.z <= z_reg;
        ge_a = a_reg.z >= z_reg;
        ge_b = b_reg.z >= z_reg;
        ge_c = c_reg.z >= z_reg;
        cr0 = le_a ^ le_b;
        cr1 = le_b ^ le_c;
        cr2 = le_c ^ le_a;
        hit_a = !(ge_a && ge_b && ge_c) && !(le_a && le_b && le_c)
                && ((cr0 && cr1) || (cr0 && cr2) || (cr1 && cr2));
        sel0 = cr0 ? EDGE_AB : EDGE_BC;
        sel1 = cr0 ? (cr1 ? EDGE_BC : EDGE_CA) : EDGE_CA;
        e0 = pick_edge(sel0, a_reg, b_reg, c_reg);
        e1 = pick_edge(sel1, a_reg, b_reg, c_reg);
        p0_a[0] = e0.p.x;  d_a[0] = sub33(e0.q.x, e0.p.x);
        p0_a[1] = e0.p.y;  d_a[1] = sub33(e0.q.y, e0.p.y);
        p0_a[2] = e1.p.x;  d_a[2] = sub33(e1.q.x, e1.p.x);
        p0_a[3] = e1.p.y;  d_a[3] = sub33(e1.q.y, e1.p.y);
        n_a[0] = sub33(z_reg, e0.p.z);  m_a[0] = sub33(e0.q.z, e0.p.z);
        n_a[2] = sub33(z_reg, e1.p.z);  m_a[2] = sub33(e1.q.z, e1.p.z);
        n_a[1] = n_a[0];  m_a[1] = m_a[0];
        n_a[3] = n_a[2];  m_a[3] = m_a[2];
    end

    // ---------------- stage B
    logic   vb_reg, hit_b_reg;
    coord_t p0_b_reg [NL];
    diff_t  d_b_reg [NL], n_b_reg [NL], m_b_reg [NL];
    diff_t  e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;

    // stage B comb
    mag_t ad_b [NL], an_b [NL], am_b [NL], anr_b [NL];
    logic neg_b [NL], byp_b [NL];
    logic signed [2*DIFF_W-1:0] pyz_b, pzy_b, pzx_b, pxz_b;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            ad_b[l]  = abs33(d_b_reg[l]);
            anr_b[l] = abs33(n_b_reg[l]);
            am_b[l]  = abs33(m_b_reg[l]);
            an_b[l]  = (anr_b[l] > am_b[l]) ? am_b[l] : anr_b[l];
            neg_b[l] = d_b_reg[l][DIFF_W-1];
            byp_b[l] = (m_b_reg[l] == '0)
                       || ((n_b_reg[l][DIFF_W-1] != m_b_reg[l][DIFF_W-1])
                           && (n_b_reg[l] != '0));
        end
        pyz_b = e1y_reg * e2z_reg;
        pzy_b = e1z_reg * e2y_reg;
        pzx_b = e1z_reg * e2x_reg;
        pxz_b = e1x_reg * e2z_reg;
    end

    // ---------------- stage C
    logic   vc_reg, hit_c_reg;
    coord_t p0_c_reg [NL];
    mag_t   ad_c_reg [NL], an_c_reg [NL], am_c_reg [NL];
    logic   neg_c_reg [NL], byp_c_reg [NL];
    logic signed [2*DIFF_W-1:0] pyz_c_reg, pzy_c_reg, pzx_c_reg, pxz_c_reg;

    logic [2*COORD_W-1:0] prod_c [NL];
    logic signed [2*DIFF_W:0] nx_c, ny_c;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            prod_c[l] = ad_c_reg[l] * an_c_reg[l];
        end
        nx_c = pyz_c_reg - pzy_c_reg;
        ny_c = pzx_c_reg - pxz_c_reg;
    end

    // ---------------- divider stages
    logic                  vd_reg  [DIV_STEPS+1];
    logic                  hit_d_reg [DIV_STEPS+1];
    logic [2*COORD_W-1:0]  w_reg   [DIV_STEPS+1][NL];
    mag_t                  dv_reg  [DIV_STEPS+1][NL];
    coord_t                p0_d_reg [DIV_STEPS+1][NL];
    logic                  neg_d_reg [DIV_STEPS+1][NL];
    logic                  byp_d_reg [DIV_STEPS+1][NL];
    logic signed [2*DIFF_W:0] nx_d_reg [DIV_STEPS+1];
    logic signed [2*DIFF_W:0] ny_d_reg [DIV_STEPS+1];

    logic [2*COORD_W-1:0] w_next [DIV_STEPS][NL];

    // one restoring step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        logic [2*COORD_W:0] t;
        logic [COORD_W:0]   top;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                t = {w_reg[k][l], 1'b0};
                top = t[2*COORD_W:COORD_W];
                if (top >= {1'b0, dv_reg[k][l]})
                begin
                    top = top - {1'b0, dv_reg[k][l]};
                    t = {top, t[COORD_W-1:1], 1'b1};
                end
                w_next[k][l] = t[2*COORD_W-1:0];
            end
        end
    end

    // ---------------- stage E: interpolated points
    logic   ve_reg, hit_e_reg;
    coord_t pt_e_reg [NL];
    logic signed [2*DIFF_W:0] nx_e_reg, ny_e_reg;

    coord_t pt_d [NL];
    always_comb
    begin
        mag_t q;
        for (int l = 0; l < NL; l++)
        begin
            q = w_reg[DIV_STEPS][l][COORD_W-1:0];
            if (byp_d_reg[DIV_STEPS][l])
                pt_d[l] = p0_d_reg[DIV_STEPS][l];
            else if (neg_d_reg[DIV_STEPS][l])
                pt_d[l] = p0_d_reg[DIV_STEPS][l] - $signed(q);
            else
                pt_d[l] = p0_d_reg[DIV_STEPS][l] + $signed(q);
        end
    end

    // ---------------- stage F: segment deltas
    logic   vf_reg, hit_f_reg;
    coord_t pt_f_reg [NL];
    diff_t  dx_f_reg, dy_f_reg;
    logic signed [2*DIFF_W:0] nx_f_reg, ny_f_reg;

    // ---------------- stage G: partial products of the orientation test
    // normal components split as hi * 2^34 + lo, lo unsigned
    localparam int LO_W = DIFF_W + 1;
    logic   vg_reg, hit_g_reg;
    coord_t pt_g_reg [NL];
    logic signed [LO_W+DIFF_W:0]     lxy_g_reg, lyx_g_reg;
    logic signed [2*DIFF_W-1:0]      hxy_g_reg, hyx_g_reg;

    logic signed [LO_W+DIFF_W:0]     lxy_f, lyx_f;
    logic signed [2*DIFF_W-1:0]      hxy_f, hyx_f;
    diff_t nxh_f, nyh_f;
    always_comb
    begin
        nxh_f = nx_f_reg[2*DIFF_W:LO_W];
        nyh_f = ny_f_reg[2*DIFF_W:LO_W];
        lxy_f = $signed({1'b0, nx_f_reg[LO_W-1:0]}) * dy_f_reg;
        lyx_f = $signed({1'b0, ny_f_reg[LO_W-1:0]}) * dx_f_reg;
        hxy_f = nxh_f * dy_f_reg;
        hyx_f = nyh_f * dx_f_reg;
    end

    // ---------------- stage H
    logic   vh_reg, hit_h_reg;
    coord_t pt_h_reg [NL];
    logic signed [LO_W+DIFF_W+1:0] lo_h_reg;
    logic signed [2*DIFF_W:0]      hi_h_reg;

    // ---------------- output
    localparam int CZ_W = 2*DIFF_W + 1 + LO_W;
    logic signed [CZ_W-1:0] cz_h;
    logic swap_h;
    logic   vo_reg, hit_o_reg;
    coord_t sx_o_reg, sy_o_reg, ex_o_reg, ey_o_reg;

    always_comb
    begin
        cz_h = ($signed({{(CZ_W-2*DIFF_W-1){hi_h_reg[2*DIFF_W]}}, hi_h_reg}) <<< LO_W)
               + $signed({{(CZ_W-LO_W-DIFF_W-2){lo_h_reg[LO_W+DIFF_W+1]}}, lo_h_reg});
        swap_h = cz_h[CZ_W-1];
    end

    // ---------------- control: valid bits and the height register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_z_reg <= '0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
                vd_reg[k] <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                slice_z_reg <= cfg.data;
            if (en)
            begin
                va_reg <= tri_in.valid;
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
                vd_reg[0] <= vc_reg;
                for (int k = 0; k < DIV_STEPS; k++)
                    vd_reg[k+1] <= vd_reg[k];
                ve_reg <= vd_reg[DIV_STEPS];
                vf_reg <= ve_reg;
                vg_reg <= vf_reg;
                vh_reg <= vg_reg;
                vo_reg <= vh_reg;
            end
        end
    end

    // ---------------- datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= '{tri_in.a_x, tri_in.a_y, tri_in.a_z};
            b_reg <= '{tri_in.b_x, tri_in.b_y, tri_in.b_z};
            c_reg <= '{tri_in.c_x, tri_in.c_y, tri_in.c_z};
            z_reg <= slice_z_reg;

            hit_b_reg <= hit_a;
            for (int l = 0; l < NL; l++)
            begin
                p0_b_reg[l] <= p0_a[l];
                d_b_reg[l]  <= d_a[l];
                n_b_reg[l]  <= n_a[l];
                m_b_reg[l]  <= m_a[l];
            end
            e1x_reg <= sub33(b_reg.x, a_reg.x);
            e1y_reg <= sub33(b_reg.y, a_reg.y);
            e1z_reg <= sub33(b_reg.z, a_reg.z);
            e2x_reg <= sub33(c_reg.x, a_reg.x);
            e2y_reg <= sub33(c_reg.y, a_reg.y);
            e2z_reg <= sub33(c_reg.z, a_reg.z);

            hit_c_reg <= hit_b_reg;
            for (int l = 0; l < NL; l++)
            begin
                p0_c_reg[l]  <= p0_b_reg[l];
                ad_c_reg[l]  <= ad_b[l];
                an_c_reg[l]  <= an_b[l];
                am_c_reg[l]  <= am_b[l];
                neg_c_reg[l] <= neg_b[l];
                byp_c_reg[l] <= byp_b[l];
            end
            pyz_c_reg <= pyz_b;
            pzy_c_reg <= pzy_b;
            pzx_c_reg <= pzx_b;
            pxz_c_reg <= pxz_b;

            hit_d_reg[0] <= hit_c_reg;
            nx_d_reg[0]  <= nx_c;
            ny_d_reg[0]  <= ny_c;
            for (int l = 0; l < NL; l++)
            begin
                w_reg[0][l]     <= prod_c[l];
                dv_reg[0][l]    <= am_c_reg[l];
                p0_d_reg[0][l]  <= p0_c_reg[l];
                neg_d_reg[0][l] <= neg_c_reg[l];
                byp_d_reg[0][l] <= byp_c_reg[l];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                hit_d_reg[k+1] <= hit_d_reg[k];
                nx_d_reg[k+1]  <= nx_d_reg[k];
                ny_d_reg[k+1]  <= ny_d_reg[k];
                for (int l = 0; l < NL; l++)
                begin
                    w_reg[k+1][l]     <= w_next[k][l];
                    dv_reg[k+1][l]    <= dv_reg[k][l];
                    p0_d_reg[k+1][l]  <= p0_d_reg[k][l];
                    neg_d_reg[k+1][l] <= neg_d_reg[k][l];
                    byp_d_reg[k+1][l] <= byp_d_reg[k][l];
                end
            end

            hit_e_reg <= hit_d_reg[DIV_STEPS];
            nx_e_reg  <= nx_d_reg[DIV_STEPS];
            ny_e_reg  <= ny_d_reg[DIV_STEPS];
            for (int l = 0; l < NL; l++)
                pt_e_reg[l] <= pt_d[l];

            hit_f_reg <= hit_e_reg;
            nx_f_reg  <= nx_e_reg;
            ny_f_reg  <= ny_e_reg;
            dx_f_reg  <= sub33(pt_e_reg[2], pt_e_reg[0]);
            dy_f_reg  <= sub33(pt_e_reg[3], pt_e_reg[1]);
            for (int l = 0; l < NL; l++)
                pt_f_reg[l] <= pt_e_reg[l];

            hit_g_reg <= hit_f_reg;
            lxy_g_reg <= lxy_f;
            lyx_g_reg <= lyx_f;
            hxy_g_reg <= hxy_f;
            hyx_g_reg <= hyx_f;
            for (int l = 0; l < NL; l++)
                pt_g_reg[l] <= pt_f_reg[l];

            hit_h_reg <= hit_g_reg;
            lo_h_reg  <= $signed({lxy_g_reg[LO_W+DIFF_W], lxy_g_reg})
                         - $signed({lyx_g_reg[LO_W+DIFF_W], lyx_g_reg});
            hi_h_reg  <= $signed({hxy_g_reg[2*DIFF_W-1], hxy_g_reg})
                         - $signed({hyx_g_reg[2*DIFF_W-1], hyx_g_reg});
            for (int l = 0; l < NL; l++)
                pt_h_reg[l] <= pt_g_reg[l];

            hit_o_reg <= hit_h_reg;
            if (!hit_h_reg)
            begin
                sx_o_reg <= '0;
                sy_o_reg <= '0;
                ex_o_reg <= '0;
                ey_o_reg <= '0;
            end
            else if (swap_h)
            begin
                sx_o_reg <= pt_h_reg[2];
                sy_o_reg <= pt_h_reg[3];
                ex_o_reg <= pt_h_reg[0];
                ey_o_reg <= pt_h_reg[1];
            end
            else
            begin
                sx_o_reg <= pt_h_reg[0];
                sy_o_reg <= pt_h_reg[1];
                ex_o_reg <= pt_h_reg[2];
                ey_o_reg <= pt_h_reg[3];
            end
        end
    end

    assign seg_out.valid   = vo_reg;
    assign seg_out.hit     = hit_o_reg;
    assign seg_out.start_x = sx_o_reg;
    assign seg_out.start_y = sy_o_reg;
    assign seg_out.end_x   = ex_o_reg;
    assign seg_out.end_y   = ey_o_reg;

endmodule

>>> hw/rtl/tzs_checker.sv
// ----------------------------------------------------------------------------
// tzs_checker: port-level checks for the triangle z-slice block
// Output hold under stall, zeroed miss results, pipeline flow control.
// ----------------------------------------------------------------------------
module tzs_checker import tzs_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input logic   out_hit,
    input coord_t out_start_x,
    input coord_t out_start_y,
    input coord_t out_end_x,
    input coord_t out_end_y
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_hit) && $stable(out_start_x)
            && $stable(out_start_y) && $stable(out_end_x) && $stable(out_end_y))
        else $error("output payload changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> out_start_x == 0 && out_start_y == 0
            && out_end_x == 0 && out_end_y == 0)
        else $error("miss result carries nonzero segment");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow pipeline advance");

endmodule

bind triangle_z_slice tzs_checker u_tzs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (tri_in.ready),
    .out_valid   (seg_out.valid),
    .out_ready   (seg_out.ready),
    .out_hit     (seg_out.hit),
    .out_start_x (seg_out.start_x),
    .out_start_y (seg_out.start_y),
    .out_end_x   (seg_out.end_x),
    .out_end_y   (seg_out.end_y)
);
